/* design/smam_pkg.sv */
// Shared types and constants for the sparse matrix add/merge core.
// Used by smam_front, smam_back and the top level; no dependencies.
package smam_pkg;

    localparam int IDX_W  = 11;
    localparam int VAL_W  = 32;
    localparam int MODE_W = 2;
    localparam int DATA_W = 56;
    localparam int USER_W = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic         REG_ROWS_IN_USE = 1'b0;
    localparam logic [IDX_W-1:0] ROWS_RESET  = 11'd1024;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        cmd_kind_t kind;
        entry_t    ent;
    } cmd_t;

    typedef struct packed {
        entry_t ent;
        logic   valid;
        logic   last;
        logic   ovf;
    } result_t;

endpackage

/* design/smam_front.sv */
// Front end: accepts input transfers, classifies the mode and queues commands.
// Depends on smam_pkg.
module smam_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smam_pkg::DATA_W-1:0]   s_tdata,
    input  logic [smam_pkg::USER_W-1:0]   s_tuser,
    output logic                          cmd_valid,
    output smam_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);

    smam_pkg::cmd_t                  q_mem [smam_pkg::Q_DEPTH];
    logic [smam_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [smam_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [smam_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    smam_pkg::cmd_t                  in_cmd;
    logic                            in_known;
    logic                            push;
    logic                            pop;

    always_comb
    begin
        in_cmd.ent.row   = s_tdata[10:0];
        in_cmd.ent.col   = s_tdata[21:11];
        in_cmd.ent.value = s_tdata[53:22];
        in_cmd.kind      = smam_pkg::CMD_COMPUTE;
        in_known         = 1'b1;
        unique case (s_tuser)
            smam_pkg::MODE_LOAD_A:  in_cmd.kind = smam_pkg::CMD_LOAD_A;
            smam_pkg::MODE_LOAD_B:  in_cmd.kind = smam_pkg::CMD_LOAD_B;
            smam_pkg::MODE_COMPUTE: in_cmd.kind = smam_pkg::CMD_COMPUTE;
            default:                in_known    = 1'b0;
        endcase
    end

    assign s_tready  = (cnt_reg != smam_pkg::Q_CNT_W'(smam_pkg::Q_DEPTH));
    assign push      = s_tvalid && s_tready && in_known;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + smam_pkg::Q_CNT_W'(push) - smam_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* design/smam_back.sv */
// Back end: holds the A and B entry stores, runs the sorted merge and drives
// the output register. Depends on smam_pkg.
module smam_back
#(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_DIM     = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  smam_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    input  logic [smam_pkg::IDX_W-1:0]    rows_in_use,
    output logic                          out_valid,
    output smam_pkg::result_t             out_res,
    input  logic                          out_ready
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    smam_pkg::entry_t    a_mem [MAX_ENTRIES];
    smam_pkg::entry_t    b_mem [MAX_ENTRIES];

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0]    b_cnt_reg, b_cnt_next;
    logic [CNT_W-1:0]    ia_reg, ia_next;
    logic [CNT_W-1:0]    ib_reg, ib_next;
    logic                ovf_reg, ovf_next;
    logic                pend_valid_reg, pend_valid_next;
    smam_pkg::result_t   pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    smam_pkg::result_t   out_reg, out_next;

    logic                a_we, b_we;
    logic                slot_free;
    smam_pkg::entry_t    ea, eb;
    logic                has_a, has_b, a_ok, b_ok;
    logic [2*smam_pkg::IDX_W-1:0] key_a, key_b;
    logic signed [smam_pkg::VAL_W:0] sum_wide;
    logic signed [smam_pkg::VAL_W-1:0] sum_sat;
    smam_pkg::result_t   r;
    logic                adv_a, adv_b;

    function automatic logic row_ok(input logic [smam_pkg::IDX_W-1:0] row,
                                    input logic [smam_pkg::IDX_W-1:0] lim);
        logic ok;
        ok = (row != '0) && (row <= lim) && ({21'b0, row} <= 32'(MAX_DIM));
        return ok;
    endfunction

    assign ea    = a_mem[ia_reg[IX_W-1:0]];
    assign eb    = b_mem[ib_reg[IX_W-1:0]];
    assign has_a = (ia_reg < a_cnt_reg);
    assign has_b = (ib_reg < b_cnt_reg);
    assign a_ok  = row_ok(ea.row, rows_in_use);
    assign b_ok  = row_ok(eb.row, rows_in_use);
    assign key_a = {ea.row, ea.col};
    assign key_b = {eb.row, eb.col};

    always_comb
    begin
        sum_wide = {ea.value[smam_pkg::VAL_W-1], ea.value}
                 + {eb.value[smam_pkg::VAL_W-1], eb.value};
        if (sum_wide[smam_pkg::VAL_W] != sum_wide[smam_pkg::VAL_W-1])
        begin
            sum_sat = sum_wide[smam_pkg::VAL_W]
                    ? {1'b1, {(smam_pkg::VAL_W-1){1'b0}}}
                    : {1'b0, {(smam_pkg::VAL_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[smam_pkg::VAL_W-1:0];
        end
    end

    always_comb
    begin
        r.valid = 1'b1;
        r.last  = 1'b0;
        r.ovf   = ovf_reg;
        adv_a   = 1'b0;
        adv_b   = 1'b0;
        if (has_a && has_b && key_a == key_b)
        begin
            r.ent       = ea;
            r.ent.value = sum_sat;
            adv_a       = 1'b1;
            adv_b       = 1'b1;
        end
        else if (has_a && (!has_b || key_a < key_b))
        begin
            r.ent = ea;
            adv_a = 1'b1;
        end
        else
        begin
            r.ent = eb;
            adv_b = 1'b1;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        a_cnt_next      = a_cnt_reg;
        b_cnt_next      = b_cnt_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cmd_pop         = 1'b0;
        a_we            = 1'b0;
        b_we            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        smam_pkg::CMD_LOAD_A:
                        begin
                            if (a_cnt_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                a_we       = 1'b1;
                                a_cnt_next = a_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        smam_pkg::CMD_LOAD_B:
                        begin
                            if (b_cnt_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                b_we       = 1'b1;
                                b_cnt_next = b_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        smam_pkg::CMD_COMPUTE:
                        begin
                            ia_next         = '0;
                            ib_next         = '0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_MERGE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                if ((has_a && !a_ok) || (has_b && !b_ok))
                begin
                    if (has_a && !a_ok)
                    begin
                        ia_next = ia_reg + 1'b1;
                    end
                    if (has_b && !b_ok)
                    begin
                        ib_next = ib_reg + 1'b1;
                    end
                end
                else if (!has_a && !has_b)
                begin
                    if (slot_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next      = pend_reg;
                            out_next.last = 1'b1;
                        end
                        else
                        begin
                            out_next.ent   = '0;
                            out_next.valid = 1'b0;
                            out_next.last  = 1'b1;
                            out_next.ovf   = ovf_reg;
                        end
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                        a_cnt_next      = '0;
                        b_cnt_next      = '0;
                        ovf_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = r;
                    pend_valid_next = 1'b1;
                    ia_next         = adv_a ? ia_reg + 1'b1 : ia_reg;
                    ib_next         = adv_b ? ib_reg + 1'b1 : ib_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_cnt_reg[IX_W-1:0]] <= cmd.ent;
        end
        if (b_we)
        begin
            b_mem[b_cnt_reg[IX_W-1:0]] <= cmd.ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            a_cnt_reg      <= '0;
            b_cnt_reg      <= '0;
            ia_reg         <= '0;
            ib_reg         <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            a_cnt_reg      <= a_cnt_next;
            b_cnt_reg      <= b_cnt_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

/* design/sparse_matrix_add_merge_core.sv */
// Top level of the sparse matrix add/merge core: configuration port, front
// queue and merge back end. Depends on smam_pkg, smam_front and smam_back.
//
// Usage:
//   The slave stream carries one item per transfer; s_tuser selects load A,
//   load B or compute, s_tdata holds row, column and value of a load.
//   Loads past capacity are dropped and flagged. A compute walks both stores
//   one step per cycle while the output is not stalled: a step takes one
//   entry, an equal-key pair, or one skipped entry from each store, and the
//   compute emits its results on the master stream, the final one with
//   m_tlast high. A result formed by the merge passes through the pending
//   register and then the output register before it leaves.
//   A four-deep command queue decouples the ports: loads keep being taken
//   while a merge runs or the receiver stalls, until the queue is full.
//   A stalled output holds its transfer and the merge pauses behind it.
//   Reset empties both stores and the queue, clears the overflow flag and
//   sets rows_in_use to 1024, at byte address 0 of the APB port. The user
//   must write it only while the block is idle; the block does not enforce it.
module sparse_matrix_add_merge_core
#(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_DIM     = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // row_index[10:0], col_index[21:11], entry_value[53:22]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_row[10:0], out_col[21:11], out_value[53:22]
    output logic [1:0]  m_tuser,   // entry_valid[0], overflow_seen[1]
    output logic        m_tlast    // last_entry
);

    logic [smam_pkg::IDX_W-1:0] rows_reg, rows_next;
    logic                       cfg_wr;
    logic                       cmd_valid;
    smam_pkg::cmd_t             cmd;
    logic                       cmd_pop;
    smam_pkg::result_t          res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == smam_pkg::REG_ROWS_IN_USE);
    assign rows_next = cfg_wr ? pwdata[10:0] : rows_reg;
    assign prdata = (paddr[2] == smam_pkg::REG_ROWS_IN_USE) ? {21'b0, rows_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= smam_pkg::ROWS_RESET;
        end
        else
        begin
            rows_reg <= rows_next;
        end
    end

    smam_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    smam_back
    #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_DIM     (MAX_DIM)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .rows_in_use (rows_reg),
        .out_valid   (m_tvalid),
        .out_res     (res),
        .out_ready   (m_tready)
    );

    assign m_tdata = {2'b00, res.ent.value, res.ent.col, res.ent.row};
    assign m_tuser = {res.ovf, res.valid};
    assign m_tlast = res.last;

endmodule

/* design/smam_checker.sv */
// Port-level checks for the sparse matrix add/merge core, bound to the top.
// Depends on sparse_matrix_add_merge_core port names only.
module smam_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                 && $stable(m_tuser) && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 56'd0))
        else $error("empty result not zero or not last");

    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[10:0] != 11'd0))
        else $error("result entry with row zero");

endmodule

bind sparse_matrix_add_merge_core smam_checker u_smam_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/smam_sum_checker.sv */
// Checker for the sparse matrix add/merge core: tracks the configuration port
// and both streams, predicts the merged triplets and compares every transfer.
// Depends on smam_pkg only.
module smam_sum_checker
#(
    parameter int MAX_ENTRIES = 32,
    parameter int MAX_DIM     = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // row_index[10:0], col_index[21:11], entry_value[53:22]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // out_row[10:0], out_col[21:11], out_value[53:22]
    input  logic [1:0]  m_tuser,   // entry_valid[0], overflow_seen[1]
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    smam_pkg::entry_t           stored [2][MAX_ENTRIES];
    int                         fill [2];
    logic                       dropped_load;
    logic [smam_pkg::IDX_W-1:0] rows_cfg;
    smam_pkg::result_t          expected_sums [$];
    int                         bad_count;
    smam_pkg::entry_t           loaded;
    smam_pkg::result_t          want;

    function automatic logic row_in_use(logic [smam_pkg::IDX_W-1:0] row, int limit);
        return row >= 1 && row <= limit;
    endfunction

    function automatic logic [2*smam_pkg::IDX_W-1:0] position(smam_pkg::entry_t e);
        return {e.row, e.col};
    endfunction

    function automatic logic [smam_pkg::VAL_W-1:0] saturated_sum(
        logic [smam_pkg::VAL_W-1:0] x,
        logic [smam_pkg::VAL_W-1:0] y);
        longint s;
        s = longint'($signed(x)) + longint'($signed(y));
        if (s > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (s < -64'sd2147483648)
            return 32'h8000_0000;
        return s[smam_pkg::VAL_W-1:0];
    endfunction

    task automatic push_sum(smam_pkg::entry_t e, logic valid);
        smam_pkg::result_t r;
        r.ent   = e;
        r.valid = valid;
        r.last  = 1'b0;
        r.ovf   = dropped_load;
        expected_sums.push_back(r);
    endtask

    task automatic predict_merge();
        int                limit;
        int                ia;
        int                ib;
        int                first;
        logic              has_a;
        logic              has_b;
        smam_pkg::entry_t  e;
        smam_pkg::result_t r;
        limit = (rows_cfg > MAX_DIM) ? MAX_DIM : int'(rows_cfg);
        ia = 0;
        ib = 0;
        first = expected_sums.size();
        forever
        begin
            while (ia < fill[0] && !row_in_use(stored[0][ia].row, limit))
                ia++;
            while (ib < fill[1] && !row_in_use(stored[1][ib].row, limit))
                ib++;
            has_a = ia < fill[0];
            has_b = ib < fill[1];
            if (!has_a && !has_b)
                break;
            if (has_a && has_b && position(stored[0][ia]) == position(stored[1][ib]))
            begin
                e = stored[0][ia];
                e.value = saturated_sum(stored[0][ia].value, stored[1][ib].value);
                push_sum(e, 1'b1);
                ia++;
                ib++;
            end
            else if (has_a && (!has_b || position(stored[0][ia]) < position(stored[1][ib])))
            begin
                push_sum(stored[0][ia], 1'b1);
                ia++;
            end
            else
            begin
                push_sum(stored[1][ib], 1'b1);
                ib++;
            end
        end
        if (expected_sums.size() == first)
            push_sum('0, 1'b0);
        r = expected_sums.pop_back();
        r.last = 1'b1;
        expected_sums.push_back(r);
        fill[0] = 0;
        fill[1] = 0;
        dropped_load = 1'b0;
    endtask

    task automatic check_field(string name, longint exp_val, longint act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            bad_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill[0] = 0;
            fill[1] = 0;
            dropped_load = 1'b0;
            rows_cfg = smam_pkg::ROWS_RESET;
            expected_sums.delete();
            bad_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr == {smam_pkg::REG_ROWS_IN_USE, 2'b00})
                rows_cfg = pwdata[smam_pkg::IDX_W-1:0];

            if (m_tvalid && m_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("unexpected transfer: row %0d col %0d value %0d",
                           m_tdata[10:0], m_tdata[21:11], $signed(m_tdata[53:22]));
                    bad_count++;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    check_field("out_row", want.ent.row, m_tdata[10:0]);
                    check_field("out_col", want.ent.col, m_tdata[21:11]);
                    check_field("out_value", longint'($signed(want.ent.value)),
                                longint'($signed(m_tdata[53:22])));
                    check_field("entry_valid", want.valid, m_tuser[0]);
                    check_field("last_entry", want.last, m_tlast);
                    check_field("overflow_seen", want.ovf, m_tuser[1]);
                end
            end

            if (s_tvalid && s_tready)
            begin
                loaded.row   = s_tdata[10:0];
                loaded.col   = s_tdata[21:11];
                loaded.value = s_tdata[53:22];
                case (s_tuser) inside
                    smam_pkg::MODE_LOAD_A, smam_pkg::MODE_LOAD_B:
                    begin
                        if (fill[s_tuser[0]] >= MAX_ENTRIES)
                            dropped_load = 1'b1;
                        else
                        begin
                            stored[s_tuser[0]][fill[s_tuser[0]]] = loaded;
                            fill[s_tuser[0]]++;
                        end
                    end
                    smam_pkg::MODE_COMPUTE:
                        predict_merge();
                    default:
                        ;
                endcase
            end

            mismatches <= bad_count;
            pending <= expected_sums.size();
        end
    end

endmodule

/* tb/sparse_matrix_add_merge_core_test.sv */
// Top of the sparse matrix add/merge testbench: clock, reset, APB writes and
// stream stimulus under several idling patterns, plus the final verdict.
// Depends on smam_pkg, sparse_matrix_add_merge_core and smam_sum_checker.
module sparse_matrix_add_merge_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [smam_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int   mismatches;
    int   pending;
    int   cycles = 0;
    int   items_sent = 0;
    int   rows_now = 1024;
    int   idle_pct = 47;
    logic idle_tx = 1'b0;
    logic idle_rx = 1'b0;

    sparse_matrix_add_merge_core dut (.*);

    smam_sum_checker checker_i (.*, .mismatches(mismatches), .pending(pending));

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= !(idle_rx && $urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(logic [smam_pkg::MODE_W-1:0] mode, int row, int col,
                             logic [31:0] value);
        while (idle_tx && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, value, col[smam_pkg::IDX_W-1:0], row[smam_pkg::IDX_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (mode != MODE_IGNORED)
            items_sent++;
    endtask

    // hold off until every expected transfer has arrived, then let the core settle
    task automatic drain(int extra);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_rows(int value);
        drain(DRAIN_CYCLES);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {smam_pkg::REG_ROWS_IN_USE, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rows_now = value;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(MODE_IGNORED, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
            1: send_item(($urandom_range(0, 1) == 0) ? smam_pkg::MODE_LOAD_A
                                                      : smam_pkg::MODE_LOAD_B,
                         $urandom_range(0, 2047), $urandom_range(0, 2047), pick_value());
            default: send_item(smam_pkg::MODE_COMPUTE, $urandom_range(0, 2047),
                               $urandom_range(0, 2047), $urandom);
        endcase
    endtask

    // sorted keys; each goes to A, to B or to both, alternating when asked
    task automatic send_merge_run(int nkeys, logic alternate);
        int row;
        int col;
        int member;
        int top_row;
        top_row = (rows_now > 1024) ? 2047 : rows_now + 4;
        row = alternate ? 1 : $urandom_range(1, top_row);
        col = $urandom_range(1, 200);
        for (int k = 0; k < nkeys; k++)
        begin
            if (k > 0)
            begin
                if (alternate || $urandom_range(0, 2) == 0)
                begin
                    row++;
                    col = $urandom_range(1, 200);
                end
                else
                    col += $urandom_range(1, 60);
            end
            member = alternate ? k % 2 : $urandom_range(0, 2);
            if (member != 1)
                send_item(smam_pkg::MODE_LOAD_A, row, col, pick_value());
            if (member != 0)
                send_item(smam_pkg::MODE_LOAD_B, row, col, pick_value());
            if (!alternate && $urandom_range(0, 9) == 0)
                send_noise();
        end
        send_item(smam_pkg::MODE_COMPUTE, $urandom_range(0, 2047),
                  $urandom_range(0, 2047), $urandom);
    endtask

    initial
    begin
        int phase_items;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(smam_pkg::MODE_COMPUTE, 2047, 2047, 32'hFFFF_FFFF);
        send_item(MODE_IGNORED, 2047, 2047, 32'hFFFF_FFFF);
        send_item(smam_pkg::MODE_LOAD_A, 1, 1, 32'h7FFF_FFFF);
        send_item(smam_pkg::MODE_LOAD_B, 1, 1, 32'h7FFF_FFFF);
        send_item(smam_pkg::MODE_LOAD_A, 1, 2, 32'h8000_0000);
        send_item(smam_pkg::MODE_LOAD_B, 1, 2, 32'hFFFF_FFFF);
        send_item(smam_pkg::MODE_LOAD_A, 1, 3, 32'd5);
        send_item(smam_pkg::MODE_LOAD_B, 1, 3, -32'sd5);
        send_item(smam_pkg::MODE_LOAD_A, 0, 4, 32'd1);
        send_item(smam_pkg::MODE_LOAD_A, 2047, 0, 32'hFFFF_FFFF);
        send_item(smam_pkg::MODE_LOAD_B, 1024, 0, 32'd123);
        send_item(smam_pkg::MODE_LOAD_B, 1, 2047, 32'd77);
        send_item(smam_pkg::MODE_LOAD_A, 1025, 5, 32'd9);
        send_item(smam_pkg::MODE_COMPUTE, 0, 0, 32'd0);

        write_rows(0);
        send_item(smam_pkg::MODE_LOAD_A, 1, 1, 32'd1);
        send_item(smam_pkg::MODE_LOAD_B, 1, 1, 32'd2);
        send_item(smam_pkg::MODE_COMPUTE, 0, 0, 32'd0);

        write_rows(1);
        send_item(smam_pkg::MODE_LOAD_A, 1, 5, 32'd3);
        send_item(smam_pkg::MODE_LOAD_A, 2, 1, 32'd4);
        send_item(smam_pkg::MODE_LOAD_B, 1, 5, -32'sd3);
        send_item(smam_pkg::MODE_COMPUTE, 0, 0, 32'd0);

        write_rows(2047);
        send_item(smam_pkg::MODE_LOAD_A, 1024, 1, 32'd1);
        send_item(smam_pkg::MODE_LOAD_A, 2047, 1, 32'd1);
        send_item(smam_pkg::MODE_COMPUTE, 0, 0, 32'd0);

        for (int sub = 0; sub < 8; sub++)
        begin
            case (sub) inside
                0, 3, 5, 7: write_rows(1024);
                2: write_rows(2);
                6: write_rows($urandom_range(1, 64));
                default: write_rows($urandom_range(1, 1024));
            endcase
            idle_tx = (sub / 2) % 2 == 1;
            idle_rx = sub >= 4;
            idle_pct = (idle_tx && idle_rx) ? 24 : 47;
            phase_items = items_sent;
            if (sub == 3)
                send_merge_run(66, 1'b1);
            while (items_sent - phase_items < 8)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_merge_run($urandom_range(20, 32), 1'b0);
                else
                    send_merge_run($urandom_range(1, 8), 1'b0);
                if ($urandom_range(0, 5) == 0)
                    drain(0);
            end
        end

        drain(DRAIN_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
design/smam_pkg.sv
design/smam_front.sv
design/smam_back.sv
design/sparse_matrix_add_merge_core.sv
design/smam_checker.sv
tb/smam_sum_checker.sv
tb/sparse_matrix_add_merge_core_test.sv
